>>> sv/ppc_pkg.sv
// Shared constants for the polygon plane clipper.
package ppc_pkg;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_KEPT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NEW  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MARK = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_NX        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NY        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NZ        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIST      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_IDX = 3'd4;

    localparam int COUNT_W    = 6;
    localparam int T_FRAC     = 16;
    localparam int DIST_SHIFT = 14;
    localparam int USER_W     = 4;

endpackage

>>> sv/ppc_fifo.sv
// Small register queue between the clipper front and back.
module ppc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> sv/ppc_front.sv
// Clipper front: plane side of each vertex, edge classification, index and count.
module ppc_front #(
    parameter int COORD_BITS     = 32,
    parameter int NORM_BITS      = 16,
    parameter int INDEX_BITS     = 16,
    parameter int MAX_POLY_VERTS = 16,
    parameter int SIDE_W         = 50,
    parameter int IN_TD          = 160,
    parameter int CFG_W          = 32,
    parameter int ENTRY_W        = 549
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]               i_cfg_data,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [IN_TD-1:0]               i_s_tdata,
    input  logic                           i_s_tlast,
    output logic                           o_push,
    output logic [ENTRY_W-1:0]             o_entry,
    input  logic                           i_full
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_SUM  = 2'd2;
    localparam logic [1:0] F_EMIT = 2'd3;
    localparam int CW      = ppc_pkg::COUNT_W;
    localparam int CNT_MAX = (2 * MAX_POLY_VERTS > 63) ? 63 : 2 * MAX_POLY_VERTS;
    localparam int PROD_W  = NORM_BITS + COORD_BITS;

    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] c;
        logic [2:0][NORM_BITS-1:0]  n;
        logic [SIDE_W-1:0]          s;
    } t_vtx;

    typedef struct packed {
        logic [ppc_pkg::KIND_W-1:0] kind;
        logic [INDEX_BITS-1:0]      idx;
        logic                       ovf;
        logic [CW-1:0]              cnt;
        logic                       done;
        logic                       run_end;
        t_vtx                       p;
        t_vtx                       b;
    } t_entry;

    logic [1:0]                   r_st;
    t_vtx                         r_cur;
    logic [INDEX_BITS-1:0]        r_idx;
    logic                         r_last;
    logic signed [PROD_W-1:0]     r_prod [3];
    t_vtx                         r_first;
    t_vtx                         r_prev;
    logic                         r_at_start;
    logic [CW-1:0]                r_cnt;
    logic [1:0]                   r_slot;
    logic [2:0][NORM_BITS-1:0]    r_nrm;
    logic [COORD_BITS-1:0]        r_dist;
    logic [INDEX_BITS-1:0]        r_next;
    logic                         r_exh;

    logic signed [SIDE_W-1:0] w_side;
    logic       w_cur_neg, w_cur_pos, w_prev_neg, w_prev_pos, w_first_neg;
    logic [3:0] w_v;
    logic [3:0] w_rest;
    logic       w_tail_empty;
    logic       w_is_new;
    logic       w_is_mark;
    logic       w_adv;
    logic [CW-1:0] w_cnt_inc;
    t_entry     w_e;

    assign o_s_tready = (r_st == F_IDLE);

    assign w_side = SIDE_W'(r_prod[0]) + SIDE_W'(r_prod[1]) + SIDE_W'(r_prod[2])
                  - (SIDE_W'($signed(r_dist)) <<< ppc_pkg::DIST_SHIFT);

    assign w_cur_neg   = r_cur.s[SIDE_W-1];
    assign w_cur_pos   = !w_cur_neg && (r_cur.s != '0);
    assign w_prev_neg  = r_prev.s[SIDE_W-1];
    assign w_prev_pos  = !w_prev_neg && (r_prev.s != '0);
    assign w_first_neg = r_first.s[SIDE_W-1];

    assign w_v[0] = r_at_start ? !w_cur_neg : (w_cur_neg ? w_prev_pos : w_prev_neg);
    assign w_v[1] = !r_at_start && !w_cur_neg;
    assign w_v[2] = r_last && (w_first_neg ? w_cur_pos : w_cur_neg);
    assign w_v[3] = r_last && !(w_v[0] || w_v[1] || w_v[2]);

    assign w_rest       = w_v >> r_slot;
    assign w_tail_empty = (w_rest[3:1] == 3'd0);
    assign w_is_new     = ((r_slot == 2'd0) && !r_at_start) || (r_slot == 2'd2);
    assign w_is_mark    = (r_slot == 2'd3);
    assign w_cnt_inc    = (r_cnt < CW'(CNT_MAX)) ? r_cnt + 1'b1 : r_cnt;

    always_comb begin
        w_e         = '0;
        w_e.done    = r_last && w_tail_empty;
        w_e.run_end = w_tail_empty;
        unique case (r_slot)
            2'd0: begin
                if (r_at_start) begin
                    w_e.kind = ppc_pkg::KIND_KEPT;
                    w_e.idx  = r_idx;
                end else begin
                    w_e.kind = ppc_pkg::KIND_NEW;
                end
                w_e.p = r_cur;
                w_e.b = r_prev;
            end
            2'd1: begin
                w_e.kind = ppc_pkg::KIND_KEPT;
                w_e.idx  = r_idx;
                w_e.p    = r_cur;
                w_e.b    = r_cur;
            end
            2'd2: begin
                w_e.kind = ppc_pkg::KIND_NEW;
                w_e.p    = r_first;
                w_e.b    = r_cur;
            end
            default: begin
                w_e.kind = ppc_pkg::KIND_MARK;
            end
        endcase
        if (w_is_new) begin
            w_e.idx = r_exh ? '1 : r_next;
            w_e.ovf = r_exh;
        end
        if (w_e.done) begin
            if (w_is_mark) begin
                w_e.cnt = (r_cnt < CW'(CNT_MAX)) ? r_cnt : r_cnt - 1'b1;
            end else begin
                w_e.cnt = w_cnt_inc;
            end
        end
    end

    assign o_entry = ENTRY_W'(w_e);
    assign o_push  = (r_st == F_EMIT) && w_v[r_slot] && !i_full;
    assign w_adv   = (r_st == F_EMIT) && (!w_v[r_slot] || !i_full);

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            F_IDLE: begin
                if (i_s_tvalid) begin
                    for (int j = 0; j < 3; j++) begin
                        r_cur.c[j] <= i_s_tdata[j*COORD_BITS +: COORD_BITS];
                        r_cur.n[j] <= i_s_tdata[3*COORD_BITS + j*NORM_BITS +: NORM_BITS];
                    end
                    r_idx  <= i_s_tdata[3*COORD_BITS + 3*NORM_BITS +: INDEX_BITS];
                    r_last <= i_s_tlast;
                end
            end
            F_MUL: begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[j] <= $signed(r_nrm[j]) * $signed(r_cur.c[j]);
                end
            end
            F_SUM: begin
                r_cur.s <= w_side;
                if (r_at_start) begin
                    r_first <= '{c: r_cur.c, n: r_cur.n, s: w_side};
                end
            end
            default: begin
                if (w_adv && (r_slot == 2'd3)) begin
                    // side reads as negative after the end of a polygon
                    r_prev <= '{c: r_cur.c, n: r_cur.n, s: {SIDE_W{r_last}} | r_cur.s};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= F_IDLE;
            r_at_start <= 1'b1;
            r_cnt      <= '0;
            r_slot     <= '0;
            r_nrm[0]   <= '0;
            r_nrm[1]   <= '0;
            r_nrm[2]   <= NORM_BITS'(16384);
            r_dist     <= COORD_BITS'(5242880);
            r_next     <= '0;
            r_exh      <= 1'b0;
        end else begin
            unique case (r_st)
                F_IDLE: begin
                    if (i_s_tvalid) begin
                        r_st <= F_MUL;
                    end
                end
                F_MUL: begin
                    r_st <= F_SUM;
                end
                F_SUM: begin
                    if (r_at_start) begin
                        r_cnt <= '0;
                    end
                    r_slot <= '0;
                    r_st   <= F_EMIT;
                end
                default: begin
                    if (o_push && !w_is_mark) begin
                        r_cnt <= w_cnt_inc;
                    end
                    if (o_push && w_is_new && !r_exh) begin
                        if (r_next == '1) begin
                            r_exh <= 1'b1;
                        end else begin
                            r_next <= r_next + 1'b1;
                        end
                    end
                    if (w_adv) begin
                        r_slot <= r_slot + 1'b1;
                        if (r_slot == 2'd3) begin
                            r_st       <= F_IDLE;
                            r_at_start <= r_last;
                            if (r_last) begin
                                r_cnt <= '0;
                            end
                        end
                    end
                end
            endcase
            if (i_cfg_we) begin
                priority case (i_cfg_idx)
                    ppc_pkg::REG_NX:   r_nrm[0] <= i_cfg_data[NORM_BITS-1:0];
                    ppc_pkg::REG_NY:   r_nrm[1] <= i_cfg_data[NORM_BITS-1:0];
                    ppc_pkg::REG_NZ:   r_nrm[2] <= i_cfg_data[NORM_BITS-1:0];
                    ppc_pkg::REG_DIST: r_dist   <= i_cfg_data[COORD_BITS-1:0];
                    ppc_pkg::REG_FIRST_IDX: begin
                        r_next <= i_cfg_data[INDEX_BITS-1:0];
                        r_exh  <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> sv/ppc_back.sv
// Clipper back: edge parameter divider, interpolation and output register.
module ppc_back #(
    parameter int COORD_BITS = 32,
    parameter int NORM_BITS  = 16,
    parameter int INDEX_BITS = 16,
    parameter int SIDE_W     = 50,
    parameter int OUT_TD     = 168,
    parameter int ENTRY_W    = 549
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  logic [ENTRY_W-1:0]          i_entry,
    output logic                        o_pop,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [OUT_TD-1:0]           o_m_tdata,
    output logic                        o_m_tlast,
    output logic [ppc_pkg::USER_W-1:0]  o_m_tuser
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_PREP = 3'd1;
    localparam logic [2:0] B_CHK  = 3'd2;
    localparam logic [2:0] B_DIV  = 3'd3;
    localparam logic [2:0] B_MUL  = 3'd4;
    localparam logic [2:0] B_OUT  = 3'd5;
    localparam int CW    = ppc_pkg::COUNT_W;
    localparam int TF    = ppc_pkg::T_FRAC;
    localparam int T_W   = TF + 1;
    localparam int IT_W  = $clog2(TF);
    localparam int NUM_W = SIDE_W + 1;
    localparam int PC_W  = COORD_BITS + T_W + 2;
    localparam int PN_W  = NORM_BITS + T_W + 2;
    localparam logic signed [PC_W:0] C_MAX =
        $signed({{(PC_W - COORD_BITS + 2){1'b0}}, {(COORD_BITS - 1){1'b1}}});
    localparam logic signed [PN_W:0] N_MAX =
        $signed({{(PN_W - NORM_BITS + 2){1'b0}}, {(NORM_BITS - 1){1'b1}}});
    localparam logic signed [PC_W:0] C_MIN = ~C_MAX;
    localparam logic signed [PN_W:0] N_MIN = ~N_MAX;

    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] c;
        logic [2:0][NORM_BITS-1:0]  n;
        logic [SIDE_W-1:0]          s;
    } t_vtx;

    typedef struct packed {
        logic [ppc_pkg::KIND_W-1:0] kind;
        logic [INDEX_BITS-1:0]      idx;
        logic                       ovf;
        logic [CW-1:0]              cnt;
        logic                       done;
        logic                       run_end;
        t_vtx                       p;
        t_vtx                       b;
    } t_entry;

    function automatic logic [COORD_BITS-1:0] sat_c(input logic signed [PC_W:0] v);
        logic [COORD_BITS-1:0] res;
        if (v > C_MAX) begin
            res = C_MAX[COORD_BITS-1:0];
        end else if (v < C_MIN) begin
            res = C_MIN[COORD_BITS-1:0];
        end else begin
            res = v[COORD_BITS-1:0];
        end
        return res;
    endfunction

    function automatic logic [NORM_BITS-1:0] sat_n(input logic signed [PN_W:0] v);
        logic [NORM_BITS-1:0] res;
        if (v > N_MAX) begin
            res = N_MAX[NORM_BITS-1:0];
        end else if (v < N_MIN) begin
            res = N_MIN[NORM_BITS-1:0];
        end else begin
            res = v[NORM_BITS-1:0];
        end
        return res;
    endfunction

    logic [2:0]                 r_st;
    t_entry                     r_e;
    logic [NUM_W-1:0]           r_num;
    logic [NUM_W-1:0]           r_den;
    logic [NUM_W-1:0]           r_rem;
    logic [T_W-1:0]             r_q;
    logic [IT_W-1:0]            r_it;
    logic signed [PC_W-1:0]     r_pc [3];
    logic signed [PN_W-1:0]     r_pn [3];
    logic                       r_ov;
    logic [ppc_pkg::KIND_W-1:0] r_o_kind;
    logic [INDEX_BITS-1:0]      r_o_idx;
    logic [2:0][COORD_BITS-1:0] r_o_c;
    logic [2:0][NORM_BITS-1:0]  r_o_n;
    logic [CW-1:0]              r_o_cnt;
    logic                       r_o_done;
    logic                       r_o_run;
    logic                       r_o_ovf;

    t_entry                   w_in;
    logic signed [NUM_W-1:0]  w_ps;
    logic signed [NUM_W-1:0]  w_d;
    logic [NUM_W:0]           w_sh;
    logic                     w_load;
    logic [2:0][COORD_BITS-1:0] w_c;
    logic [2:0][NORM_BITS-1:0]  w_n;

    assign w_in   = t_entry'(i_entry);
    assign o_pop  = (r_st == B_IDLE) && !i_empty;
    assign w_ps   = NUM_W'($signed(r_e.p.s));
    assign w_d    = NUM_W'($signed(r_e.p.s)) - NUM_W'($signed(r_e.b.s));
    assign w_sh   = {r_rem, 1'b0};
    assign w_load = (r_st == B_OUT) && (!r_ov || i_m_tready);

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_c[j] = sat_c(((-(PC_W+1)'(r_pc[j])) >>> TF)
                           + (PC_W+1)'($signed(r_e.p.c[j])));
            w_n[j] = sat_n(((-(PN_W+1)'(r_pn[j])) >>> TF)
                           + (PN_W+1)'($signed(r_e.p.n[j])));
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            B_IDLE: begin
                if (!i_empty) begin
                    r_e <= w_in;
                end
            end
            B_PREP: begin
                r_num <= w_ps[NUM_W-1] ? -w_ps : w_ps;
                r_den <= w_d[NUM_W-1] ? -w_d : w_d;
            end
            B_CHK: begin
                r_rem <= r_num;
                r_it  <= '0;
                if (r_den == '0) begin
                    r_q <= '0;
                end else if (r_num >= r_den) begin
                    r_q <= T_W'(1) << TF;
                end else begin
                    r_q <= '0;
                end
            end
            B_DIV: begin
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= NUM_W'(w_sh - {1'b0, r_den});
                    r_q   <= {r_q[T_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh[NUM_W-1:0];
                    r_q   <= {r_q[T_W-2:0], 1'b0};
                end
                r_it <= r_it + 1'b1;
            end
            B_MUL: begin
                for (int j = 0; j < 3; j++) begin
                    r_pc[j] <= ((COORD_BITS+1)'($signed(r_e.p.c[j]))
                              - (COORD_BITS+1)'($signed(r_e.b.c[j])))
                              * $signed({1'b0, r_q});
                    r_pn[j] <= ((NORM_BITS+1)'($signed(r_e.p.n[j]))
                              - (NORM_BITS+1)'($signed(r_e.b.n[j])))
                              * $signed({1'b0, r_q});
                end
            end
            B_OUT: begin
                if (w_load) begin
                    r_o_kind <= r_e.kind;
                    r_o_idx  <= r_e.idx;
                    r_o_cnt  <= r_e.cnt;
                    r_o_done <= r_e.done;
                    r_o_run  <= r_e.run_end;
                    r_o_ovf  <= r_e.ovf;
                    if (r_e.kind == ppc_pkg::KIND_NEW) begin
                        r_o_c <= w_c;
                        r_o_n <= w_n;
                    end else begin
                        r_o_c <= r_e.p.c;
                        r_o_n <= r_e.p.n;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= B_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_ov <= w_load || (r_ov && !i_m_tready);
            unique case (r_st)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_st <= (w_in.kind == ppc_pkg::KIND_NEW) ? B_PREP : B_OUT;
                    end
                end
                B_PREP: r_st <= B_CHK;
                B_CHK: begin
                    r_st <= ((r_den == '0) || (r_num >= r_den)) ? B_MUL : B_DIV;
                end
                B_DIV: begin
                    if (r_it == IT_W'(TF - 1)) begin
                        r_st <= B_MUL;
                    end
                end
                B_MUL: r_st <= B_OUT;
                B_OUT: begin
                    if (w_load) begin
                        r_st <= B_IDLE;
                    end
                end
                default: r_st <= B_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tlast  = r_o_done;
    assign o_m_tuser  = {r_o_ovf, r_o_run, r_o_kind};
    assign o_m_tdata  = OUT_TD'({r_o_cnt, r_o_n[2], r_o_n[1], r_o_n[0],
                                 r_o_c[2], r_o_c[1], r_o_c[0], r_o_idx});

endmodule

>>> sv/polygon_plane_clipper.sv
// Top level of the single-plane polygon clipper.
//
// channel   dir  handshake               contents
// s         in   i_s_tvalid/o_s_tready   tdata vertex word, tlast last vertex of polygon
// m         out  o_m_tvalid/i_m_tready   tdata result word, tlast polygon done, tuser flags
// cfg       in   i_cfg_we                register write, no wait
//
// Front takes a new vertex only after side product, sum and four result slots; the
// slots wait while the queue is full. Back: kept vertex or end marker goes straight to
// output; a new vertex passes prepare, check, the one-bit-per-cycle divider for t
// (skipped when t saturates to 1 or the divisor is zero), multiply and output.
// A 4-word queue lets front and back stall apart.
// Output register holds a word until taken; synchronous active-low reset.
module polygon_plane_clipper #(
    parameter int COORD_BITS     = 32,
    parameter int NORM_BITS      = 16,
    parameter int INDEX_BITS     = 16,
    parameter int MAX_POLY_VERTS = 16,
    localparam int CFG_W  = (COORD_BITS > NORM_BITS)
                          ? ((COORD_BITS > INDEX_BITS) ? COORD_BITS : INDEX_BITS)
                          : ((NORM_BITS > INDEX_BITS) ? NORM_BITS : INDEX_BITS),
    localparam int IN_W   = 3 * COORD_BITS + 3 * NORM_BITS + INDEX_BITS,
    localparam int IN_TD  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W  = INDEX_BITS + 3 * COORD_BITS + 3 * NORM_BITS + ppc_pkg::COUNT_W,
    localparam int OUT_TD = ((OUT_W + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]               i_cfg_data,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, vertex_index
    input  logic [IN_TD-1:0]               i_s_tdata,
    input  logic                           i_s_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // out_index, out_x, out_y, out_z, out_nx, out_ny, out_nz, poly_count
    output logic [OUT_TD-1:0]              o_m_tdata,
    output logic                           o_m_tlast,
    // kind, run_end, index_overflow
    output logic [ppc_pkg::USER_W-1:0]     o_m_tuser
);

    localparam int SIDE_W  = ((NORM_BITS > ppc_pkg::DIST_SHIFT) ? NORM_BITS
                             : ppc_pkg::DIST_SHIFT) + COORD_BITS + 2;
    localparam int VTX_W   = 3 * COORD_BITS + 3 * NORM_BITS + SIDE_W;
    localparam int ENTRY_W = ppc_pkg::KIND_W + INDEX_BITS + 1 + ppc_pkg::COUNT_W + 2
                           + 2 * VTX_W;
    localparam int QDEPTH  = 4;

    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_empty;
    logic [ENTRY_W-1:0] w_wr;
    logic [ENTRY_W-1:0] w_rd;

    ppc_front #(
        .COORD_BITS     (COORD_BITS),
        .NORM_BITS      (NORM_BITS),
        .INDEX_BITS     (INDEX_BITS),
        .MAX_POLY_VERTS (MAX_POLY_VERTS),
        .SIDE_W         (SIDE_W),
        .IN_TD          (IN_TD),
        .CFG_W          (CFG_W),
        .ENTRY_W        (ENTRY_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_push     (w_push),
        .o_entry    (w_wr),
        .i_full     (w_full)
    );

    ppc_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_wr),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_rd),
        .o_empty (w_empty)
    );

    ppc_back #(
        .COORD_BITS (COORD_BITS),
        .NORM_BITS  (NORM_BITS),
        .INDEX_BITS (INDEX_BITS),
        .SIDE_W     (SIDE_W),
        .OUT_TD     (OUT_TD),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_entry    (w_rd),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
